// ===== rtl/wmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Wiper motor controller package
// Shared state codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wmc_pkg;

  // Wiper state, also the value shown on the result beat
  typedef enum logic [2:0] {
    StParked  = 3'd0,
    StParking = 3'd1,
    StSlow    = 3'd2,
    StFast    = 3'd3,
    StInterOn = 3'd4,
    StPause   = 3'd5,
    StWash    = 3'd6,
    StSwipe   = 3'd7
  } wiper_state_e;

  // Input source selection
  typedef enum logic [1:0] {
    ModeSwitches = 2'd0,
    ModeSelector = 2'd1,
    ModeMixed    = 2'd2,
    ModeNone     = 2'd3
  } input_mode_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    RegEnable     = 3'd0,
    RegInputMode  = 3'd1,
    RegParkStop   = 3'd2,
    RegWashCycles = 3'd3,
    RegSpeedMap   = 3'd4,
    RegPauseDly   = 3'd5,
    RegSpare6     = 3'd6,
    RegSpare7     = 3'd7
  } cfg_reg_e;

  // Selector map codes
  localparam logic [3:0] CodePark      = 4'd0;
  localparam logic [3:0] CodeSlow      = 4'd1;
  localparam logic [3:0] CodeFast      = 4'd2;
  localparam logic [3:0] InterCodeBase = 4'd3;
  localparam logic [3:0] InterCodeLast = 4'd8;

  localparam int DelayUnitMs = 100;
  localparam int DelayW      = 15;
  localparam int CfgDataW    = 48;

  // A speed request: valid flag plus the requested state
  typedef struct packed {
    logic         valid;
    wiper_state_e target;
  } speed_req_t;

endpackage

`default_nettype wire

// ===== rtl/wiper_motor_controller.sv =====
// ----------------------------------------------------------------------------
// Wiper motor controller
// Tick-driven wiper state machine with wash, swipe and intermittent timing.
// ----------------------------------------------------------------------------
//  channel   dir  width  contents
//  s_axis    in   40+3   tdata: time, switches; tuser: speed_select
//  m_axis    out  8      tdata: slow_drive, fast_drive, wiper_state
//  cfg       in   3+48   register index, write data
//
// One beat per cycle sustained while m_axis does not stall.
// A tick sits in the input register, the state update is one pass of logic
// into the result register, and state commits as the tick moves on.
// A stall on m_axis holds the result; the input register still takes one beat.
// Reset clears state, config and both valid flags.
`timescale 1ns / 1ps
`default_nettype none

module wiper_motor_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: [31:0] time_now_ms, [32] slow_switch, [33] fast_switch,
  //        [34] inter_switch, [35] on_switch, [36] park_switch,
  //        [37] wash_switch, [38] swipe_switch, [39] zero
  input  wire logic [39:0] s_axis_tdata,
  // tuser: [2:0] speed_select
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: [0] slow_drive, [1] fast_drive, [4:2] wiper_state, [7:5] zero
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);

  localparam int DW = wmc_pkg::DelayW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                     enable_q;
  wmc_pkg::input_mode_e     input_mode_q;
  logic                     park_stop_q;
  logic [3:0]               wash_cycles_q;
  logic [31:0]              speed_map_q;
  logic [47:0]              pause_delays_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q       <= 1'b0;
      input_mode_q   <= wmc_pkg::ModeSwitches;
      park_stop_q    <= 1'b0;
      wash_cycles_q  <= 4'd0;
      speed_map_q    <= 32'd0;
      pause_delays_q <= 48'd0;
    end else if (cfg_we_i) begin
      unique case (wmc_pkg::cfg_reg_e'(cfg_idx_i))
        wmc_pkg::RegEnable:     enable_q       <= cfg_data_i[0];
        wmc_pkg::RegInputMode:  input_mode_q   <= wmc_pkg::input_mode_e'(cfg_data_i[1:0]);
        wmc_pkg::RegParkStop:   park_stop_q    <= cfg_data_i[0];
        wmc_pkg::RegWashCycles: wash_cycles_q  <= cfg_data_i[3:0];
        wmc_pkg::RegSpeedMap:   speed_map_q    <= cfg_data_i[31:0];
        wmc_pkg::RegPauseDly:   pause_delays_q <= cfg_data_i[47:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register and handshake
  // --------------------------------------------------------------------------
  logic        in_valid_q;
  logic [31:0] time_q;
  logic        sl_q, fa_q, it_q, on_q, park_q, wash_q, swipe_q;
  logic [2:0]  sel_q;
  logic        advance;
  logic        s_accept;

  assign advance       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      time_q  <= s_axis_tdata[31:0];
      sl_q    <= s_axis_tdata[32];
      fa_q    <= s_axis_tdata[33];
      it_q    <= s_axis_tdata[34];
      on_q    <= s_axis_tdata[35];
      park_q  <= s_axis_tdata[36];
      wash_q  <= s_axis_tdata[37];
      swipe_q <= s_axis_tdata[38];
      sel_q   <= s_axis_tuser;
    end
  end

  // --------------------------------------------------------------------------
  // Controller state
  // --------------------------------------------------------------------------
  wmc_pkg::wiper_state_e st_q, st_d;
  wmc_pkg::wiper_state_e saved_q, saved_d;
  logic [31:0]           pstart_q, pstart_d;
  logic [DW-1:0]         dly_q, dly_d;
  logic [3:0]            wipe_q, wipe_d;
  logic                  prevp_q, prevp_d;
  logic [1:0]            drive_q, drive_d;

  // --------------------------------------------------------------------------
  // Speed request decode (selector map and switches)
  // --------------------------------------------------------------------------
  logic [3:0]          code;
  logic [2:0]          dly_idx;
  logic [7:0]          dly_byte;
  logic [DW-1:0]       map_dly;
  logic                map_is_inter;
  wmc_pkg::speed_req_t map_req;
  wmc_pkg::speed_req_t mu_req;
  logic                mu_dly_v;
  logic [DW-1:0]       mu_dly;
  logic [7:0]          byte0;

  assign code         = speed_map_q[{sel_q, 2'b00} +: 4];
  assign map_is_inter = (code >= wmc_pkg::InterCodeBase) && (code <= wmc_pkg::InterCodeLast);
  assign dly_idx      = 3'(code - wmc_pkg::InterCodeBase);
  assign dly_byte     = pause_delays_q[{dly_idx, 3'b000} +: 8];
  assign map_dly      = DW'({7'd0, dly_byte} * DW'(wmc_pkg::DelayUnitMs));
  assign byte0        = pause_delays_q[7:0];

  always_comb begin
    map_req = '{valid: 1'b0, target: wmc_pkg::StParked};
    if (code == wmc_pkg::CodeSlow) begin
      map_req = '{valid: 1'b1, target: wmc_pkg::StSlow};
    end else if (code == wmc_pkg::CodeFast) begin
      map_req = '{valid: 1'b1, target: wmc_pkg::StFast};
    end else if (map_is_inter) begin
      map_req = '{valid: 1'b1, target: wmc_pkg::StInterOn};
    end
  end

  always_comb begin
    mu_req   = '{valid: 1'b0, target: wmc_pkg::StParked};
    mu_dly_v = 1'b0;
    mu_dly   = map_dly;
    unique case (input_mode_q)
      wmc_pkg::ModeSwitches: begin
        mu_dly = DW'({7'd0, byte0} * DW'(wmc_pkg::DelayUnitMs));
        if (it_q) begin
          mu_dly_v = 1'b1;
          mu_req   = '{valid: 1'b1, target: wmc_pkg::StInterOn};
        end
        if (sl_q) mu_req = '{valid: 1'b1, target: wmc_pkg::StSlow};
        if (fa_q) mu_req = '{valid: 1'b1, target: wmc_pkg::StFast};
        // own switch released: park, wins over the other switch requests
        if ((st_q == wmc_pkg::StFast && !fa_q) || (st_q == wmc_pkg::StSlow && !sl_q) ||
            ((st_q == wmc_pkg::StInterOn || st_q == wmc_pkg::StPause) && !it_q)) begin
          mu_req = '{valid: 1'b1, target: wmc_pkg::StParking};
        end
      end
      wmc_pkg::ModeSelector: begin
        mu_dly_v = map_is_inter;
        if (code == wmc_pkg::CodePark) mu_req = '{valid: 1'b1, target: wmc_pkg::StParking};
        else mu_req = map_req;
      end
      wmc_pkg::ModeMixed: begin
        mu_dly_v = map_is_inter;
        if (!on_q) mu_req = '{valid: 1'b1, target: wmc_pkg::StParking};
        if (map_req.valid) mu_req = map_req;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // State update for one tick
  // --------------------------------------------------------------------------
  wmc_pkg::speed_req_t req;
  wmc_pkg::wiper_state_e nxt;
  logic [31:0]           elapsed;
  logic [3:0]            wipe_inc;

  assign elapsed = time_q - pstart_q;

  always_comb begin
    st_d     = st_q;
    saved_d  = saved_q;
    pstart_d = pstart_q;
    dly_d    = dly_q;
    wipe_d   = wipe_q;
    prevp_d  = prevp_q;
    drive_d  = drive_q;
    req      = '{valid: 1'b0, target: wmc_pkg::StParked};
    nxt      = st_q;
    wipe_inc = wipe_q;
    if (enable_q) begin
      // states that evaluate speed requests may reload the pause delay
      if (st_q == wmc_pkg::StParked || st_q == wmc_pkg::StSlow || st_q == wmc_pkg::StFast ||
          st_q == wmc_pkg::StInterOn || st_q == wmc_pkg::StPause) begin
        req = mu_req;
        if (mu_dly_v) dly_d = mu_dly;
      end
      unique case (st_q)
        wmc_pkg::StParked: begin
          drive_d = 2'b00;
          if (req.target == wmc_pkg::StParking) req.valid = 1'b0;
        end
        wmc_pkg::StParking: begin
          if (park_q == park_stop_q) begin
            drive_d = 2'b00;
            nxt     = wmc_pkg::StParked;
          end
        end
        wmc_pkg::StSlow: drive_d = 2'b01;
        wmc_pkg::StFast: drive_d = 2'b11;
        wmc_pkg::StInterOn: begin
          drive_d = 2'b01;
          if (!park_q) begin
            pstart_d = time_q;
            nxt      = wmc_pkg::StPause;
          end
        end
        wmc_pkg::StPause: begin
          drive_d = 2'b00;
          if (elapsed > {{(32-DW){1'b0}}, dly_d}) begin
            drive_d = 2'b01;
            nxt     = wmc_pkg::StInterOn;
          end
        end
        wmc_pkg::StWash: begin
          drive_d = (saved_q == wmc_pkg::StFast) ? 2'b11 : 2'b01;
          if (wash_q) begin
            wipe_d = 4'd0;
          end else begin
            // count falling edges of the park switch, saturating
            if (!park_q && prevp_q && wipe_q != 4'hF) wipe_inc = wipe_q + 4'd1;
            wipe_d = wipe_inc;
            if (wipe_inc >= wash_cycles_q) begin
              req.valid = 1'b1;
              if (saved_q == wmc_pkg::StParked) req.target = wmc_pkg::StParking;
              else if (saved_q == wmc_pkg::StPause) req.target = wmc_pkg::StInterOn;
              else req.target = saved_q;
            end
          end
          prevp_d = park_q;
        end
        wmc_pkg::StSwipe: begin
          drive_d = 2'b11;
          if (park_q) nxt = wmc_pkg::StParking;
        end
        default: ;
      endcase
      // intermittent request while cycling is ignored
      if ((st_q == wmc_pkg::StInterOn || st_q == wmc_pkg::StPause) &&
          req.target == wmc_pkg::StInterOn) begin
        req.valid = 1'b0;
      end
      if (req.valid) nxt = req.target;
      if (wash_q) begin
        if (st_q != wmc_pkg::StWash) saved_d = st_q;
        nxt = wmc_pkg::StWash;
      end
      if (swipe_q) nxt = wmc_pkg::StSwipe;
      st_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= wmc_pkg::StParked;
      saved_q  <= wmc_pkg::StParked;
      pstart_q <= 32'd0;
      dly_q    <= '0;
      wipe_q   <= 4'd0;
      prevp_q  <= 1'b0;
      drive_q  <= 2'b00;
    end else if (advance) begin
      st_q     <= st_d;
      saved_q  <= saved_d;
      pstart_q <= pstart_d;
      dly_q    <= dly_d;
      wipe_q   <= wipe_d;
      prevp_q  <= prevp_d;
      drive_q  <= drive_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic       out_valid_q;
  logic [7:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {3'b000, st_d, drive_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // fast line never runs without the slow line
  a_drive_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_q != 2'b10) else $error("fast drive without slow drive");

  // the saved pre-wash state is never wash itself
  a_saved_not_wash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    saved_q != wmc_pkg::StWash) else $error("saved state is wash");

  // disabled block keeps its state across ticks
  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !enable_q) |=> ($stable(st_q) && $stable(drive_q)))
    else $error("state changed while disabled");

  // input side only stalls when a tick is held and the result is blocked
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without cause");

  // a committed tick shows its new state on the result beat
  a_result_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (m_axis_tvalid && m_axis_tdata[4:2] == st_q && m_axis_tdata[1:0] == drive_q))
    else $error("result beat does not match committed state");

endmodule

`default_nettype wire

// ===== dv/tb_wiper_motor_controller.sv =====
// ----------------------------------------------------------------------------
// Wiper motor controller testbench
// Drives ticks on the input stream and checks every result beat against a
// behavioral model of the wiper state machine kept inside the bench. A short
// directed table covers reset hold, each state, timer wrap, wash and swipe,
// all input modes and unused selector codes. Random phases follow, each with
// a fresh register setting, held switch levels with a turning park switch,
// wash and swipe pulses and some noise. Both streams idle in random bursts
// except in the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_wiper_motor_controller;

  localparam int NumPhases     = 10;
  localparam int TicksPerPhase = 50;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 8;

  // Switch masks for the directed table, bit order as in tdata[38:32]
  localparam logic [6:0] SwSlow  = 7'h01;
  localparam logic [6:0] SwFast  = 7'h02;
  localparam logic [6:0] SwInter = 7'h04;
  localparam logic [6:0] SwOn    = 7'h08;
  localparam logic [6:0] SwPark  = 7'h10;
  localparam logic [6:0] SwWash  = 7'h20;
  localparam logic [6:0] SwSwipe = 7'h40;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [6:0]  sw;       // swipe, wash, park, on, inter, fast, slow
    logic [2:0]  sel;
  } tick_t;

  typedef struct packed {
    logic                  slow_drv;
    logic                  fast_drv;
    wmc_pkg::wiper_state_e state;
  } wiper_out_t;

  localparam wiper_out_t OffParked = '{slow_drv: 1'b0, fast_drv: 1'b0,
                                       state: wmc_pkg::StParked};

  typedef struct {
    logic              is_cfg;
    wmc_pkg::cfg_reg_e idx;
    logic [47:0]       val;
    tick_t             tick;
    logic              chk;
    wiper_out_t        want;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic [39:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [47:0] cfg_data_i;

  wiper_motor_controller DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Register copies seen by the model
  logic                 en_r;
  wmc_pkg::input_mode_e mode_r;
  logic                 park_stop_r;
  logic [3:0]           wash_cycles_r;
  logic [31:0]          speed_map_r;
  logic [47:0]          pause_dly_r;

  // Model state
  wmc_pkg::wiper_state_e wiper_st_q;
  wmc_pkg::wiper_state_e saved_st_q;
  logic [31:0]           pause_start_q;
  logic [14:0]           pause_ms_q;
  logic [3:0]            wipe_cnt_q;
  logic                  prev_park_q;
  logic [3:0]            sel_code_q;
  logic [1:0]            motor_q;     // bit0 slow line, bit1 fast line

  wiper_out_t   drive_q[$];  // expected result beats, oldest first
  int unsigned  err_cnt;
  logic         idle_en;

  function automatic dir_row_t cfg_row(wmc_pkg::cfg_reg_e idx, logic [47:0] val);
    dir_row_t r;
    r = '{is_cfg: 1'b1, idx: idx, val: val, tick: '0, chk: 1'b0, want: OffParked};
    return r;
  endfunction

  function automatic dir_row_t tick_row(logic [31:0] ms, logic [6:0] sw, logic [2:0] sel);
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: wmc_pkg::RegEnable, val: '0, tick: '{ms, sw, sel}, chk: 1'b0,
          want: OffParked};
    return r;
  endfunction

  function automatic dir_row_t tick_chk(logic [31:0] ms, logic [6:0] sw, logic [2:0] sel,
                                       wiper_out_t want);
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: wmc_pkg::RegEnable, val: '0, tick: '{ms, sw, sel}, chk: 1'b1,
          want: want};
    return r;
  endfunction

  function automatic logic [14:0] pause_ms_for(int k);
    logic [31:0] ms;
    ms = pause_dly_r[8*k +: 8] * wmc_pkg::DelayUnitMs;
    return ms[14:0];
  endfunction

  task automatic flag_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // Selector code to request; intermittent codes also load the pause delay
  task automatic code_request(input logic [3:0] code, output logic vld,
                              output wmc_pkg::wiper_state_e tgt);
    vld = 1'b0;
    tgt = wmc_pkg::StParked;
    if (code == wmc_pkg::CodeSlow) begin
      vld = 1'b1;
      tgt = wmc_pkg::StSlow;
    end else if (code == wmc_pkg::CodeFast) begin
      vld = 1'b1;
      tgt = wmc_pkg::StFast;
    end else if (code >= wmc_pkg::InterCodeBase && code <= wmc_pkg::InterCodeLast) begin
      pause_ms_q = pause_ms_for(int'(code - wmc_pkg::InterCodeBase));
      vld = 1'b1;
      tgt = wmc_pkg::StInterOn;
    end
  endtask

  task automatic speed_request(input tick_t t, output logic vld,
                               output wmc_pkg::wiper_state_e tgt);
    logic                  v2;
    wmc_pkg::wiper_state_e t2;
    vld = 1'b0;
    tgt = wmc_pkg::StParked;
    case (mode_r)
      wmc_pkg::ModeSwitches: begin
        if (t.sw[2]) begin
          pause_ms_q = pause_ms_for(0);
          vld = 1'b1;
          tgt = wmc_pkg::StInterOn;
        end
        if (t.sw[0]) begin
          vld = 1'b1;
          tgt = wmc_pkg::StSlow;
        end
        if (t.sw[1]) begin
          vld = 1'b1;
          tgt = wmc_pkg::StFast;
        end
        // own switch released: park, and this wins
        if ((wiper_st_q == wmc_pkg::StFast && !t.sw[1]) ||
            (wiper_st_q == wmc_pkg::StSlow && !t.sw[0]) ||
            ((wiper_st_q == wmc_pkg::StInterOn || wiper_st_q == wmc_pkg::StPause) &&
             !t.sw[2])) begin
          vld = 1'b1;
          tgt = wmc_pkg::StParking;
        end
      end
      wmc_pkg::ModeSelector: begin
        sel_code_q = speed_map_r[4*t.sel +: 4];
        if (sel_code_q == wmc_pkg::CodePark) begin
          vld = 1'b1;
          tgt = wmc_pkg::StParking;
        end else begin
          code_request(sel_code_q, vld, tgt);
        end
      end
      wmc_pkg::ModeMixed: begin
        sel_code_q = speed_map_r[4*t.sel +: 4];
        if (!t.sw[3]) begin
          vld = 1'b1;
          tgt = wmc_pkg::StParking;
        end
        code_request(sel_code_q, v2, t2);
        if (v2) begin
          vld = 1'b1;
          tgt = t2;
        end
      end
      default: ;
    endcase
  endtask

  // One tick of the wiper state machine
  task automatic wiper_step(input tick_t t, output wiper_out_t o);
    wmc_pkg::wiper_state_e cur, nxt, req_st;
    logic                  req_vld;
    logic [31:0]           elapsed;
    logic                  park;
    if (en_r) begin
      cur = wiper_st_q;
      nxt = cur;
      req_vld = 1'b0;
      req_st = wmc_pkg::StParked;
      park = t.sw[4];
      case (cur)
        wmc_pkg::StParked: begin
          motor_q = 2'b00;
          speed_request(t, req_vld, req_st);
          if (req_vld && req_st == wmc_pkg::StParking) req_vld = 1'b0;
        end
        wmc_pkg::StParking: begin
          if (park == park_stop_r) begin
            motor_q = 2'b00;
            nxt = wmc_pkg::StParked;
          end
        end
        wmc_pkg::StSlow: begin
          motor_q = 2'b01;
          speed_request(t, req_vld, req_st);
        end
        wmc_pkg::StFast: begin
          motor_q = 2'b11;
          speed_request(t, req_vld, req_st);
        end
        wmc_pkg::StInterOn: begin
          motor_q = 2'b01;
          speed_request(t, req_vld, req_st);
          if (!park) begin
            pause_start_q = t.time_ms;
            nxt = wmc_pkg::StPause;
          end
        end
        wmc_pkg::StPause: begin
          motor_q = 2'b00;
          speed_request(t, req_vld, req_st);
          elapsed = t.time_ms - pause_start_q;
          if (elapsed > {17'd0, pause_ms_q}) begin
            motor_q = 2'b01;
            nxt = wmc_pkg::StInterOn;
          end
        end
        wmc_pkg::StWash: begin
          motor_q = (saved_st_q == wmc_pkg::StFast) ? 2'b11 : 2'b01;
          if (t.sw[5]) begin
            wipe_cnt_q = '0;
          end else begin
            // count falling park edges after release
            if (!park && park != prev_park_q && wipe_cnt_q < 4'd15) wipe_cnt_q++;
            if (wipe_cnt_q >= wash_cycles_r) begin
              req_vld = 1'b1;
              if (saved_st_q == wmc_pkg::StParked) req_st = wmc_pkg::StParking;
              else if (saved_st_q == wmc_pkg::StPause) req_st = wmc_pkg::StInterOn;
              else req_st = saved_st_q;
            end
          end
          prev_park_q = park;
        end
        default: begin
          motor_q = 2'b11;
          if (park) nxt = wmc_pkg::StParking;
        end
      endcase
      // intermittent request while cycling leaves the on/pause loop alone
      if ((cur == wmc_pkg::StInterOn || cur == wmc_pkg::StPause) && req_vld &&
          req_st == wmc_pkg::StInterOn)
        req_vld = 1'b0;
      if (req_vld) nxt = req_st;
      if (t.sw[5]) begin
        if (cur != wmc_pkg::StWash) saved_st_q = cur;
        nxt = wmc_pkg::StWash;
      end
      if (t.sw[6]) nxt = wmc_pkg::StSwipe;
      wiper_st_q = nxt;
    end
    o.slow_drv = motor_q[0];
    o.fast_drv = motor_q[1];
    o.state = wiper_st_q;
  endtask

  // Register write once the block has drained
  task automatic write_reg(input wmc_pkg::cfg_reg_e idx, input logic [47:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      wmc_pkg::RegEnable:     en_r = val[0];
      wmc_pkg::RegInputMode:  mode_r = wmc_pkg::input_mode_e'(val[1:0]);
      wmc_pkg::RegParkStop:   park_stop_r = val[0];
      wmc_pkg::RegWashCycles: wash_cycles_r = val[3:0];
      wmc_pkg::RegSpeedMap:   speed_map_r = val[31:0];
      wmc_pkg::RegPauseDly:   pause_dly_r = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Send one tick; on acceptance push the expected beat
  task automatic drive_tick(input tick_t t, input logic chk, input wiper_out_t want);
    wiper_out_t pred;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, t.sw, t.time_ms};
    s_axis_tuser <= t.sel;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    wiper_step(t, pred);
    drive_q.push_back(chk ? want : pred);
  endtask

  // Result side: random backpressure bursts
  initial begin : rx_side
    int hold;
    hold = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : chk_side
    wiper_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.slow_drv = m_axis_tdata[0];
      got.fast_drv = m_axis_tdata[1];
      got.state = wmc_pkg::wiper_state_e'(m_axis_tdata[4:2]);
      if (drive_q.size() == 0) begin
        flag_error($sformatf("result beat %h with nothing expected", m_axis_tdata));
      end else begin
        want = drive_q.pop_front();
        if (got.slow_drv !== want.slow_drv)
          flag_error($sformatf("slow_drive got %b want %b", got.slow_drv, want.slow_drv));
        if (got.fast_drv !== want.fast_drv)
          flag_error($sformatf("fast_drive got %b want %b", got.fast_drv, want.fast_drv));
        if (got.state !== want.state)
          flag_error($sformatf("wiper_state got %0d want %0d", got.state, want.state));
      end
    end
  end

  // Watchdog on cycles with no beat and no register write
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i ||
        !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim
    dir_row_t             dir_tab[$];
    tick_t                t;
    logic [6:0]           lvl;
    logic [2:0]           sel_lvl;
    logic [31:0]          now_ms;
    logic [31:0]          map_v;
    logic [47:0]          dly_v;
    int                   wash_left;
    logic                 en_v;
    wmc_pkg::input_mode_e mode_v;
    logic                 stop_v;
    logic [3:0]           wash_v;

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = wmc_pkg::RegEnable;
    cfg_data_i = '0;
    idle_en = 1'b1;
    err_cnt = 0;

    en_r = 1'b0;
    mode_r = wmc_pkg::ModeSwitches;
    park_stop_r = 1'b0;
    wash_cycles_r = '0;
    speed_map_r = '0;
    pause_dly_r = '0;
    wiper_st_q = wmc_pkg::StParked;
    saved_st_q = wmc_pkg::StParked;
    pause_start_q = '0;
    pause_ms_q = '0;
    wipe_cnt_q = '0;
    prev_park_q = 1'b0;
    sel_code_q = '0;
    motor_q = 2'b00;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table
    dir_tab.push_back(tick_chk(32'hFFFF_FFFF, 7'h7F, 3'd7, OffParked));  // disabled: hold
    dir_tab.push_back(tick_chk(32'h0, 7'h00, 3'd0, OffParked));
    dir_tab.push_back(cfg_row(wmc_pkg::RegEnable, 48'd1));
    dir_tab.push_back(tick_row(32'd100, SwSlow, 3'd0));
    dir_tab.push_back(tick_row(32'd200, SwSlow | SwFast, 3'd0));
    dir_tab.push_back(tick_row(32'd300, 7'h00, 3'd0));                    // release: parking
    dir_tab.push_back(tick_row(32'd400, SwPark, 3'd0));
    dir_tab.push_back(tick_chk(32'd500, 7'h00, 3'd0, OffParked));        // park reached
    dir_tab.push_back(tick_row(32'd600, SwInter | SwPark, 3'd0));
    dir_tab.push_back(tick_row(32'hFFFF_FFF0, SwInter, 3'd0));           // pause starts
    dir_tab.push_back(tick_row(32'hFFFF_FFF0, SwInter, 3'd0));           // zero elapsed
    dir_tab.push_back(tick_row(32'h0000_0005, SwInter | SwPark, 3'd0));  // time wrap
    dir_tab.push_back(tick_row(32'd700, SwInter | SwPark | SwWash, 3'd0));
    dir_tab.push_back(tick_row(32'd800, SwWash, 3'd0));
    dir_tab.push_back(tick_row(32'd900, SwPark, 3'd0));                  // wash release
    dir_tab.push_back(tick_row(32'd1000, SwInter | SwSwipe, 3'd0));
    dir_tab.push_back(tick_row(32'd1100, SwInter | SwPark, 3'd0));
    dir_tab.push_back(cfg_row(wmc_pkg::RegParkStop, 48'd1));
    dir_tab.push_back(cfg_row(wmc_pkg::RegWashCycles, 48'd15));
    dir_tab.push_back(cfg_row(wmc_pkg::RegInputMode, 48'(wmc_pkg::ModeSelector)));
    dir_tab.push_back(cfg_row(wmc_pkg::RegSpeedMap, 48'h5F98_3210));
    dir_tab.push_back(cfg_row(wmc_pkg::RegPauseDly, 48'hFF00_0000_0001));
    dir_tab.push_back(tick_chk(32'd1200, SwPark, 3'd0, OffParked));
    dir_tab.push_back(tick_row(32'd1300, 7'h00, 3'd4));                  // last inter code
    dir_tab.push_back(tick_row(32'd1400, 7'h00, 3'd5));                  // unused code
    dir_tab.push_back(tick_row(32'd1500, 7'h00, 3'd6));                  // code 15
    dir_tab.push_back(cfg_row(wmc_pkg::RegInputMode, 48'(wmc_pkg::ModeMixed)));
    dir_tab.push_back(tick_row(32'd1600, 7'h00, 3'd1));                  // slow beats on low
    dir_tab.push_back(tick_row(32'd1700, 7'h00, 3'd0));
    dir_tab.push_back(cfg_row(wmc_pkg::RegInputMode, 48'(wmc_pkg::ModeNone)));
    dir_tab.push_back(tick_row(32'd1800, SwSlow | SwFast | SwInter | SwOn | SwPark, 3'd2));
    dir_tab.push_back(tick_chk(32'd1900, SwSlow | SwFast, 3'd2, OffParked));
    dir_tab.push_back(cfg_row(wmc_pkg::RegEnable, 48'd0));
    dir_tab.push_back(tick_chk(32'd2000, SwWash | SwSwipe, 3'd0, OffParked));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].idx, dir_tab[i].val);
      else drive_tick(dir_tab[i].tick, dir_tab[i].chk, dir_tab[i].want);
    end

    // Random phases, each with a new register setting
    now_ms = $urandom;
    lvl = '0;
    sel_lvl = '0;
    wash_left = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0) begin
        en_v = 1'b1;
        mode_v = wmc_pkg::ModeMixed;
        stop_v = 1'b1;
        wash_v = 4'd15;
        map_v = 32'hFFFF_FFFF;
        dly_v = 48'hFFFF_FFFF_FFFF;
      end else if (ph == 1) begin
        en_v = 1'b1;
        mode_v = wmc_pkg::ModeSwitches;
        stop_v = 1'b0;
        wash_v = 4'd0;
        map_v = '0;
        dly_v = '0;
      end else begin
        en_v = ($urandom_range(0, 7) != 0);
        mode_v = ($urandom_range(0, 9) == 0) ? wmc_pkg::ModeNone
                                             : wmc_pkg::input_mode_e'($urandom_range(0, 2));
        stop_v = 1'($urandom_range(0, 1));
        wash_v = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(0, 3));
        for (int k = 0; k < 8; k++)
          map_v[4*k +: 4] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8));
        for (int k = 0; k < 6; k++)
          dly_v[8*k +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 5));
      end
      write_reg(wmc_pkg::RegEnable, 48'(en_v));
      write_reg(wmc_pkg::RegInputMode, 48'(mode_v));
      write_reg(wmc_pkg::RegParkStop, 48'(stop_v));
      write_reg(wmc_pkg::RegWashCycles, 48'(wash_v));
      write_reg(wmc_pkg::RegSpeedMap, 48'(map_v));
      write_reg(wmc_pkg::RegPauseDly, dly_v);
      idle_en = (ph < NumPhases - 1);

      for (int n = 0; n < TicksPerPhase; n++) begin
        // Held levels that change now and then, park turning with the motor
        for (int b = 0; b < 4; b++)
          if ($urandom_range(0, 7) == 0) lvl[b] = ~lvl[b];
        if ($urandom_range(0, 2) == 0) lvl[4] = ~lvl[4];
        if (wash_left > 0) wash_left--;
        else if ($urandom_range(0, 24) == 0) wash_left = $urandom_range(1, 4);
        lvl[5] = (wash_left > 0);
        lvl[6] = ($urandom_range(0, 39) == 0);
        if ($urandom_range(0, 5) == 0) sel_lvl = 3'($urandom_range(0, 7));
        // Mostly small steps of time, sometimes a long gap or a jump anywhere
        if ($urandom_range(0, 49) == 0) now_ms = $urandom;
        else if ($urandom_range(0, 19) == 0) now_ms = now_ms + $urandom_range(0, 30000);
        else now_ms = now_ms + $urandom_range(0, 400);
        t = '{now_ms, lvl, sel_lvl};
        if ($urandom_range(0, 9) == 0) begin
          t.sw = 7'($urandom_range(0, 127));
          t.sel = 3'($urandom_range(0, 7));
        end
        drive_tick(t, 1'b0, OffParked);
      end
    end

    // Drain and finish
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (drive_q.size() != 0) flag_error("expected beats left over at end of run");
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wmc_pkg.sv
rtl/wiper_motor_controller.sv
dv/tb_wiper_motor_controller.sv
